/* sv/aff_pkg.sv */
// shared types for the 2d affine inverse block
// no dependencies
package aff_pkg;

  typedef struct packed {
    logic valid;
    logic det_neg;
    logic det_zero;
  } div_ctl_t;

endpackage

/* sv/affine_inverse_2d.sv */
// top level of the 2d affine inverse: pipeline around a divider cell chain
// depends on aff_pkg, aff_div_cell, aff_round_fit
//
// s_tdata carries one transform per request, m_tdata its inverse.
// s_tdata fields from bit 0: lin_xx, lin_xy, lin_yx, lin_yy, shift_x, shift_y.
// m_tdata fields from bit 0: inv_xx, inv_xy, inv_yx, inv_yy, inv_shift_x,
// inv_shift_y; m_tuser holds singular, and all data is zero when it is set.
// A fully pipelined block: one transform per cycle is taken and delivered while the output is not stalled.
// The pipeline is the divider chain of 3*FRAC_BITS+1 cells, one quotient
// bit per cell, plus the decode, product, difference, reciprocal rounding,
// scaling, combine and output stages. All stages advance together; when
// m_tready is low with a result waiting, the whole pipe holds and s_tready
// drops, so nothing is lost. Synchronous reset clears every valid flag;
// the pipe is empty afterwards.
module affine_inverse_2d #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // lin_xx, lin_xy, lin_yx, lin_yy, shift_x, shift_y
  input  logic [((6*DATA_WIDTH+7)/8)*8-1:0]   s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // inv_xx, inv_xy, inv_yx, inv_yy, inv_shift_x, inv_shift_y
  output logic [((6*DATA_WIDTH+7)/8)*8-1:0]   m_tdata,
  // singular
  output logic                                m_tuser
);

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int TW  = ((6*W+7)/8)*8;
  localparam int PW  = 2*W;
  localparam int DW  = 2*W + 1;
  localparam int RW  = DW + 1;
  localparam int QW  = 3*F + 1;
  localparam int NC  = QW;
  localparam int QXW = (QW + 1 > W + 1) ? QW + 1 : W + 1;
  localparam int PL  = 4 + 4*W + 2*(DW + 1);
  localparam int XW  = DW + W;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  function automatic logic [DW:0] sdiff(logic an, logic [PW-1:0] am,
                                        logic bn, logic [PW-1:0] bm);
    logic [DW-1:0] ae;
    logic [DW-1:0] be;
    ae = {1'b0, am};
    be = {1'b0, bm};
    if (an != bn) begin
      return {an, ae + be};
    end else if (ae >= be) begin
      return {an, ae - be};
    end else begin
      return {!an, be - ae};
    end
  endfunction

  // decode to sign and magnitude
  logic         a_valid;
  logic [5:0]   a_n;
  logic [W-1:0] a_m [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= s_tvalid;
    end
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        a_n[i]    <= s_tdata[i*W + W - 1];
        a_m[i]    <= s_tdata[i*W + W - 1] ? (~s_tdata[i*W +: W] + W'(1))
                                          : s_tdata[i*W +: W];
      end
    end
  end

  // products: xx*yy, xy*yx, yx*sy, yy*sx, xy*sx, xx*sy
  logic          b_valid;
  logic [5:0]    b_pn;
  logic [PW-1:0] b_p [6];
  logic [3:0]    b_n;
  logic [W-1:0]  b_m [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
    if (en) begin
      b_p[0] <= a_m[0] * a_m[3];  b_pn[0] <= a_n[0] ^ a_n[3];
      b_p[1] <= a_m[1] * a_m[2];  b_pn[1] <= a_n[1] ^ a_n[2];
      b_p[2] <= a_m[2] * a_m[5];  b_pn[2] <= a_n[2] ^ a_n[5];
      b_p[3] <= a_m[3] * a_m[4];  b_pn[3] <= a_n[3] ^ a_n[4];
      b_p[4] <= a_m[1] * a_m[4];  b_pn[4] <= a_n[1] ^ a_n[4];
      b_p[5] <= a_m[0] * a_m[5];  b_pn[5] <= a_n[0] ^ a_n[5];
      for (int i = 0; i < 4; i++) begin
        b_n[i] <= a_n[i];
        b_m[i] <= a_m[i];
      end
    end
  end

  // determinant and translation numerators
  aff_pkg::div_ctl_t c_ctl0;
  logic [DW-1:0]     c_d0;
  logic [PL-1:0]     c_pl0;
  logic [DW:0]       det_w;
  logic [DW:0]       nx_w;
  logic [DW:0]       ny_w;

  assign det_w = sdiff(b_pn[0], b_p[0], b_pn[1], b_p[1]);
  assign nx_w  = sdiff(b_pn[2], b_p[2], b_pn[3], b_p[3]);
  assign ny_w  = sdiff(b_pn[4], b_p[4], b_pn[5], b_p[5]);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_ctl0 <= '0;
    end else if (en) begin
      c_ctl0.valid    <= b_valid;
      c_ctl0.det_neg  <= det_w[DW];
      c_ctl0.det_zero <= (det_w[DW-1:0] == '0);
    end
    if (en) begin
      c_d0  <= det_w[DW-1:0];
      c_pl0 <= {b_n, b_m[0], b_m[1], b_m[2], b_m[3], nx_w, ny_w};
    end
  end

  // divider chain
  aff_pkg::div_ctl_t c_ctl [NC+1];
  logic [DW-1:0]     c_d   [NC+1];
  logic [RW-1:0]     c_r   [NC+1];
  logic [QW-1:0]     c_q   [NC+1];
  logic [PL-1:0]     c_pl  [NC+1];

  assign c_ctl[0] = c_ctl0;
  assign c_d[0]   = c_d0;
  assign c_r[0]   = '0;
  assign c_q[0]   = '0;
  assign c_pl[0]  = c_pl0;

  for (genvar k = 0; k < NC; k++) begin : g_cell
    aff_div_cell #(
      .RW    (RW),
      .QW    (QW),
      .PL    (PL),
      .FIRST (k == 0)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .ctl_in  (c_ctl[k]),
      .d_in    (c_d[k]),
      .r_in    (c_r[k]),
      .q_in    (c_q[k]),
      .pl_in   (c_pl[k]),
      .ctl_out (c_ctl[k+1]),
      .d_out   (c_d[k+1]),
      .r_out   (c_r[k+1]),
      .q_out   (c_q[k+1]),
      .pl_out  (c_pl[k+1])
    );
  end

  // reciprocal rounding and range
  logic [3:0]     x_n;
  logic [W-1:0]   x_m [4];
  logic [DW:0]    x_nx;
  logic [DW:0]    x_ny;
  logic           rnd;
  logic [QXW-1:0] qr;
  logic [QXW-1:0] qlim;

  assign {x_n, x_m[0], x_m[1], x_m[2], x_m[3], x_nx, x_ny} = c_pl[NC];
  assign rnd  = ({c_r[NC][RW-2:0], 1'b0} >= {1'b0, c_d[NC]});
  assign qr   = QXW'(c_q[NC]) + QXW'(rnd);
  assign qlim = (QXW'(1) << (W - 1)) - QXW'(!c_ctl[NC].det_neg);

  logic         e_valid;
  logic         e_ok;
  logic         e_rn;
  logic [W-1:0] e_r;
  logic [3:0]   e_n;
  logic [W-1:0] e_m [4];
  logic [DW:0]  e_nx;
  logic [DW:0]  e_ny;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en) begin
      e_valid <= c_ctl[NC].valid;
    end
    if (en) begin
      e_ok <= !c_ctl[NC].det_zero && (qr != '0) && (qr <= qlim);
      e_rn <= c_ctl[NC].det_neg;
      e_r  <= qr[W-1:0];
      e_n  <= x_n;
      for (int i = 0; i < 4; i++) begin
        e_m[i] <= x_m[i];
      end
      e_nx <= x_nx;
      e_ny <= x_ny;
    end
  end

  // scaling by the reciprocal
  logic          f_valid;
  logic          f_ok;
  logic [3:0]    f_n;
  logic [PW-1:0] f_t [4];
  logic          f_nxn;
  logic          f_nyn;
  logic [PW-1:0] f_nxl;
  logic [PW:0]   f_nxh;
  logic [PW-1:0] f_nyl;
  logic [PW:0]   f_nyh;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= e_valid;
    end
    if (en) begin
      f_ok   <= e_ok;
      f_t[0] <= e_m[3] * e_r;  f_n[0] <= e_n[3] ^ e_rn;
      f_t[1] <= e_m[1] * e_r;  f_n[1] <= !(e_n[1] ^ e_rn);
      f_t[2] <= e_m[2] * e_r;  f_n[2] <= !(e_n[2] ^ e_rn);
      f_t[3] <= e_m[0] * e_r;  f_n[3] <= e_n[0] ^ e_rn;
      f_nxn  <= e_nx[DW] ^ e_rn;
      f_nyn  <= e_ny[DW] ^ e_rn;
      f_nxl  <= e_nx[W-1:0] * e_r;
      f_nxh  <= e_nx[DW-1:W] * e_r;
      f_nyl  <= e_ny[W-1:0] * e_r;
      f_nyh  <= e_ny[DW-1:W] * e_r;
    end
  end

  // partial product combine
  logic          g_valid;
  logic          g_ok;
  logic [3:0]    g_n;
  logic [PW-1:0] g_t [4];
  logic          g_nxn;
  logic          g_nyn;
  logic [XW-1:0] g_nx;
  logic [XW-1:0] g_ny;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else if (en) begin
      g_valid <= f_valid;
    end
    if (en) begin
      g_ok  <= f_ok;
      g_n   <= f_n;
      for (int i = 0; i < 4; i++) begin
        g_t[i] <= f_t[i];
      end
      g_nxn <= f_nxn;
      g_nyn <= f_nyn;
      g_nx  <= {f_nxh, {W{1'b0}}} + XW'(f_nxl);
      g_ny  <= {f_nyh, {W{1'b0}}} + XW'(f_nyl);
    end
  end

  // final rounding and output register
  logic [5:0]   fit_ok;
  logic [W-1:0] fit_v [6];

  for (genvar i = 0; i < 4; i++) begin : g_lin
    aff_round_fit #(.IW(PW), .K(F), .W(W)) u_fit (
      .neg (g_n[i]),
      .mag (g_t[i]),
      .ok  (fit_ok[i]),
      .val (fit_v[i])
    );
  end

  aff_round_fit #(.IW(XW), .K(2*F), .W(W)) u_fit_x (
    .neg (g_nxn),
    .mag (g_nx),
    .ok  (fit_ok[4]),
    .val (fit_v[4])
  );

  aff_round_fit #(.IW(XW), .K(2*F), .W(W)) u_fit_y (
    .neg (g_nyn),
    .mag (g_ny),
    .ok  (fit_ok[5]),
    .val (fit_v[5])
  );

  logic          all_ok;
  logic [TW-1:0] out_data;
  assign all_ok = g_ok && (fit_ok == 6'b111111);

  always_comb begin
    out_data = '0;
    for (int i = 0; i < 6; i++) begin
      out_data[i*W +: W] = all_ok ? fit_v[i] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= g_valid;
    end
    if (en) begin
      m_tdata <= out_data;
      m_tuser <= !all_ok;
    end
  end

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("singular result with nonzero data");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("request taken while output stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result present after reset");

endmodule

/* sv/aff_div_cell.sv */
// one cell of the reciprocal divider chain: one quotient bit per cell
// depends on aff_pkg
module aff_div_cell #(
  parameter int RW    = 66,
  parameter int QW    = 49,
  parameter int PL    = 200,
  parameter bit FIRST = 1'b0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  aff_pkg::div_ctl_t ctl_in,
  input  logic [RW-2:0]     d_in,
  input  logic [RW-1:0]     r_in,
  input  logic [QW-1:0]     q_in,
  input  logic [PL-1:0]     pl_in,
  output aff_pkg::div_ctl_t ctl_out,
  output logic [RW-2:0]     d_out,
  output logic [RW-1:0]     r_out,
  output logic [QW-1:0]     q_out,
  output logic [PL-1:0]     pl_out
);

  logic [RW-1:0] r2;
  logic          ge;

  assign r2 = {r_in[RW-2:0], FIRST};
  assign ge = (r2 >= {1'b0, d_in});

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
    if (en) begin
      d_out  <= d_in;
      r_out  <= ge ? (r2 - {1'b0, d_in}) : r2;
      q_out  <= {q_in[QW-2:0], ge};
      pl_out <= pl_in;
    end
  end

endmodule

/* sv/aff_round_fit.sv */
// rounds a sign/magnitude value by a right shift, checks the signed range
// no dependencies
module aff_round_fit #(
  parameter int IW = 97,
  parameter int K  = 32,
  parameter int W  = 32
) (
  input  logic          neg,
  input  logic [IW-1:0] mag,
  output logic          ok,
  output logic [W-1:0]  val
);

  logic [IW:0] m;
  logic [IW:0] sh;
  logic [IW:0] lim;

  assign m   = {1'b0, mag} + ((IW+1)'(1) << (K - 1));
  assign sh  = m >> K;
  assign lim = ((IW+1)'(1) << (W - 1)) - (IW+1)'(!neg);
  assign ok  = (sh <= lim);
  assign val = neg ? (~sh[W-1:0] + W'(1)) : sh[W-1:0];

endmodule
